// File: rtl/krs_pkg.sv
// ----------------------------------------------------------------------------
// krs_pkg: shared types and constants of the key release scanner
// Payload structs, key codes, register indexes and widths used by the
// scanner top level and its key encoder.
// ----------------------------------------------------------------------------
package krs_pkg;

  // Width of the internal altitude setpoint counter.
  localparam int ALT_WIDTH = 16;
  localparam int KEY_W     = 4;
  localparam int PINS_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_ALT_W = 16;

  // Key codes with a special meaning.
  localparam logic [KEY_W-1:0] KEY_NONE = 4'd0;
  localparam logic [KEY_W-1:0] KEY_MODE = 4'd5;
  localparam logic [KEY_W-1:0] KEY_UP   = 4'd6;
  localparam logic [KEY_W-1:0] KEY_DOWN = 4'd8;

  // Item actions.
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_CONSUME = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_STEP      = 1'd1;

  // Register reset values.
  localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 8'd20;
  localparam logic [CFG_W-1:0] ALT_STEP_RST      = 8'd1;

  typedef struct packed {
    logic              action;
    logic [PINS_W-1:0] keys_low;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key_event;
    logic [KEY_W-1:0]     last_key;
    logic                 mode_flag;
    logic [OUT_ALT_W-1:0] altitude_setpoint;
  } out_t;

endpackage

// File: rtl/krs_key_enc.sv
// ----------------------------------------------------------------------------
// krs_key_enc: priority encoder for the active-low button pins
// The lowest pin that reads low gives code (pin index + 1); no pressed pin
// gives code zero.
// ----------------------------------------------------------------------------
module krs_key_enc (
  input  logic [krs_pkg::PINS_W-1:0] keys_low,
  output logic [krs_pkg::KEY_W-1:0]  key_code
);
  import krs_pkg::*;

  // Scan from the top pin down so that the lowest pressed pin wins.
  always_comb begin
    key_code = KEY_NONE;
    for (int i = PINS_W - 1; i >= 0; i--) begin
      if (!keys_low[i]) begin
        key_code = KEY_W'(i + 1);
      end
    end
  end

endmodule

// File: rtl/key_release_scanner.sv
// ----------------------------------------------------------------------------
// key_release_scanner: release-triggered button scanner with setpoint control
// Samples eight active-low buttons, detects key releases and applies the
// consumed key to a mode bit and a saturating altitude setpoint.
// ----------------------------------------------------------------------------
// Usage: each input beat on in_data is either a tick (action 0), which
// carries the current pin levels, or a consume request (action 1). Every beat
// produces exactly one result beat on out_data. A tick advances the sample
// counter and, once every sample_period ticks, samples the priority-encoded
// key; a sample of zero after a nonzero sample makes the earlier key pending.
// A consume hands out the pending key in key_event and applies it: key 5
// toggles the mode flag, key 6 raises and key 8 lowers the altitude setpoint.
// Each result is registered. Throughput is one beat per cycle while the
// receiver takes results; the single result register sets this figure,
// since all state updates finish in the cycle of acceptance. When the
// receiver stalls, the result register holds its beat and in_ready drops
// until out_ready frees it. Synchronous reset clears all state and the
// output valid, and loads sample_period = 20 and
// altitude_step = 1. Configuration is written through cfg_we/cfg_index/
// cfg_wdata while no beat is in flight; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module key_release_scanner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  krs_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output krs_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [krs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [krs_pkg::CFG_W-1:0]     cfg_wdata
);
  import krs_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] sample_period_r;
  logic [CFG_W-1:0] alt_step_r;

  // Scanner and control state. The previous sample is the current sample
  // register itself at the moment a new sample is taken, so it needs no
  // register of its own.
  logic [7:0]           tick_count_r,  tick_count_nxt;
  logic [KEY_W-1:0]     cur_sample_r,  cur_sample_nxt;
  logic [KEY_W-1:0]     pending_r,     pending_nxt;
  logic [KEY_W-1:0]     recorded_r,    recorded_nxt;
  logic                 mode_r,        mode_nxt;
  logic [ALT_WIDTH-1:0] alt_r,         alt_nxt;

  // Result register.
  logic out_valid_r;
  out_t out_data_r, out_data_nxt;

  logic                 in_acc;
  logic [KEY_W-1:0]     key_code;
  logic [7:0]           tick_inc;
  logic [ALT_WIDTH:0]   alt_sum;
  logic [ALT_WIDTH-1:0] step_ext;
  logic [KEY_W-1:0]     event_key;

  krs_key_enc u_key_enc (
    .keys_low (in_data.keys_low),
    .key_code (key_code)
  );

  // The result register is the only skid: a new beat enters whenever the
  // register is empty or is being drained in this cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tick_inc = tick_count_r + 8'd1;
  assign step_ext = ALT_WIDTH'(alt_step_r);
  // One extra bit catches the overflow for the saturating raise.
  assign alt_sum  = {1'b0, alt_r} + {1'b0, step_ext};

  always_comb begin
    tick_count_nxt  = tick_count_r;
    cur_sample_nxt  = cur_sample_r;
    pending_nxt     = pending_r;
    recorded_nxt    = recorded_r;
    mode_nxt        = mode_r;
    alt_nxt         = alt_r;
    event_key       = KEY_NONE;

    if (in_data.action == ACT_TICK) begin
      tick_count_nxt = tick_inc;
      if (tick_inc >= sample_period_r) begin
        tick_count_nxt  = 8'd0;
        cur_sample_nxt  = key_code;
        // A release: the key went away since the previous sample.
        if (key_code == KEY_NONE && cur_sample_r != KEY_NONE) begin
          pending_nxt = cur_sample_r;
        end
      end
    end else begin
      event_key   = pending_r;
      pending_nxt = KEY_NONE;
      if (pending_r != KEY_NONE) begin
        recorded_nxt = pending_r;
      end
      if (pending_r == KEY_MODE) begin
        mode_nxt = !mode_r;
      end else if (pending_r == KEY_UP) begin
        alt_nxt = alt_sum[ALT_WIDTH] ? {ALT_WIDTH{1'b1}} : alt_sum[ALT_WIDTH-1:0];
      end else if (pending_r == KEY_DOWN) begin
        alt_nxt = (alt_r < step_ext) ? '0 : alt_r - step_ext;
      end
    end

    out_data_nxt.key_event         = event_key;
    out_data_nxt.last_key          = recorded_nxt;
    out_data_nxt.mode_flag         = mode_nxt;
    out_data_nxt.altitude_setpoint = OUT_ALT_W'(alt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= SAMPLE_PERIOD_RST;
      alt_step_r      <= ALT_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata;
        CFG_ALT_STEP:      alt_step_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r  <= '0;
      cur_sample_r  <= KEY_NONE;
      pending_r     <= KEY_NONE;
      recorded_r    <= KEY_NONE;
      mode_r        <= 1'b0;
      alt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        tick_count_r  <= tick_count_nxt;
        cur_sample_r  <= cur_sample_nxt;
        pending_r     <= pending_nxt;
        recorded_r    <= recorded_nxt;
        mode_r        <= mode_nxt;
        alt_r         <= alt_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A consume beat reports the key that was pending when it was accepted.
  a_consume_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.action == ACT_CONSUME |=>
      out_data_r.key_event == $past(pending_r) && pending_r == KEY_NONE)
    else $error("consume did not report and clear the pending key");

  // A tick beat never reports a key event.
  a_tick_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.action == ACT_TICK |=> out_data_r.key_event == KEY_NONE)
    else $error("tick reported a key event");

  // Raising the setpoint never makes it smaller, and lowering never larger.
  a_alt_up: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.action == ACT_CONSUME && pending_r == KEY_UP |=>
      alt_r >= $past(alt_r))
    else $error("setpoint raise wrapped");

  a_alt_down: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.action == ACT_CONSUME && pending_r == KEY_DOWN |=>
      alt_r <= $past(alt_r))
    else $error("setpoint lower wrapped");

  // The pending key, setpoint and mode change only when a beat is accepted.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(pending_r) && $stable(alt_r) && $stable(mode_r))
    else $error("state changed without an accepted beat");

endmodule
